FILE: rtl/mcfe_pkg.sv
// ----------------------------------------------------------------------------
// mcfe_pkg
// Shared types, constants and command tables for the motor command frame
// encoder.
// ----------------------------------------------------------------------------
package mcfe_pkg;

  // frame constants
  localparam logic [7:0] HDR_MAGIC    = 8'h3E;
  localparam logic [4:0] HDR_SUM_POS  = 5'd4;
  localparam logic [4:0] HDR_BYTES    = 5'd4;
  localparam logic [4:0] DATA_START   = 5'd5;

  // command code bytes
  localparam logic [7:0] CODE_CONNECT   = 8'h10;
  localparam logic [7:0] CODE_SERVO_OFF = 8'h80;
  localparam logic [7:0] CODE_SERVO_ON  = 8'h88;
  localparam logic [7:0] CODE_READ_POS  = 8'h92;
  localparam logic [7:0] CODE_MOVE      = 8'hA3;
  localparam logic [7:0] CODE_MOVE_SPD  = 8'hA4;
  localparam logic [7:0] CODE_SET_POS   = 8'h95;

  // field widths
  localparam int ANGLE_W = 64;
  localparam int SPEED_W = 32;
  localparam int QUOT_W  = 32;
  localparam int PAY_W   = 96;
  localparam int HDR_W   = 32;

  // divide by ten, one 16-bit digit per step by reciprocal multiply
  localparam int DIV_DIGIT_W = 16;
  localparam int DIV_X_W     = DIV_DIGIT_W + 4;
  localparam int DIV_PROD_W  = 2 * DIV_X_W;
  localparam int DIV_STEPS   = ANGLE_W / DIV_DIGIT_W;
  localparam int DIV_STEP_W  = 2;
  localparam int DIV_SHIFT   = 23;
  // ceil(2^23 / 10), exact for every digit step value below 2^22
  localparam logic [DIV_X_W-1:0]    DIV_RECIP     = 20'hCCCCD;
  localparam logic [DIV_STEP_W-1:0] DIV_LAST_STEP = DIV_STEP_W'(DIV_STEPS - 1);

  // command selector (code 7 is unused and dropped)
  typedef enum logic [2:0] {
    ACT_CONNECT   = 3'd0,
    ACT_SERVO_OFF = 3'd1,
    ACT_SERVO_ON  = 3'd2,
    ACT_READ_POS  = 3'd3,
    ACT_MOVE      = 3'd4,
    ACT_MOVE_SPD  = 3'd5,
    ACT_SET_POS   = 3'd6
  } action_t;

  // framer sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_t;

  // command code byte
  function automatic logic [7:0] cmd_code(input logic [2:0] act);
    logic [7:0] code;
    case (act)
      ACT_CONNECT:   code = CODE_CONNECT;
      ACT_SERVO_OFF: code = CODE_SERVO_OFF;
      ACT_SERVO_ON:  code = CODE_SERVO_ON;
      ACT_READ_POS:  code = CODE_READ_POS;
      ACT_MOVE:      code = CODE_MOVE;
      ACT_MOVE_SPD:  code = CODE_MOVE_SPD;
      ACT_SET_POS:   code = CODE_SET_POS;
      default:       code = 8'h00;
    endcase
    return code;
  endfunction

  // data length in bytes
  function automatic logic [4:0] cmd_len(input logic [2:0] act);
    logic [4:0] len;
    case (act)
      ACT_MOVE:     len = 5'd8;
      ACT_MOVE_SPD: len = 5'd12;
      ACT_SET_POS:  len = 5'd4;
      default:      len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

FILE: rtl/mcfe_div10.sv
// ----------------------------------------------------------------------------
// mcfe_div10
// Iterative signed divide by ten, truncating toward zero. The 64-bit magnitude
// is walked in four 16-bit digits, one per cycle, each divided by a shared
// reciprocal multiply; returns the low 32 quotient bits.
// ----------------------------------------------------------------------------
module mcfe_div10 (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [mcfe_pkg::ANGLE_W-1:0] dividend,
  output logic                                done,
  output logic        [mcfe_pkg::QUOT_W-1:0]  quotient
);

  logic                                busy_r, busy_nxt;
  logic                                done_r, done_nxt;
  logic [mcfe_pkg::DIV_STEP_W-1:0]     step_r, step_nxt;
  logic                                neg_r;
  logic [mcfe_pkg::ANGLE_W-1:0]        mag_r;
  logic [3:0]                          rem_r;
  logic [mcfe_pkg::QUOT_W-1:0]         quot_r;
  logic [mcfe_pkg::DIV_X_W-1:0]        x;
  logic [mcfe_pkg::DIV_PROD_W-1:0]     prod;
  logic [mcfe_pkg::DIV_DIGIT_W-1:0]    qd;
  logic [mcfe_pkg::DIV_X_W-1:0]        tenq;
  logic [mcfe_pkg::DIV_X_W-1:0]        diff;

  // one digit step: remainder and next digit over ten, then the new remainder
  always_comb begin
    x    = {rem_r, mag_r[mcfe_pkg::ANGLE_W-1 -: mcfe_pkg::DIV_DIGIT_W]};
    prod = {{(mcfe_pkg::DIV_PROD_W - mcfe_pkg::DIV_X_W){1'b0}}, x} *
           {{(mcfe_pkg::DIV_PROD_W - mcfe_pkg::DIV_X_W){1'b0}}, mcfe_pkg::DIV_RECIP};
    qd   = prod[mcfe_pkg::DIV_SHIFT +: mcfe_pkg::DIV_DIGIT_W];
    tenq = {1'b0, qd, 3'b000} + {3'b000, qd, 1'b0};
    diff = x - tenq;
  end

  // control
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
    end else if (busy_r) begin
      step_nxt = step_r + 1'b1;
      if (step_r == mcfe_pkg::DIV_LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  // magnitude digit shifter, remainder and quotient digits
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[mcfe_pkg::ANGLE_W-1];
      mag_r <= dividend[mcfe_pkg::ANGLE_W-1] ?
               (~dividend + {{(mcfe_pkg::ANGLE_W-1){1'b0}}, 1'b1}) : dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      mag_r  <= {mag_r[mcfe_pkg::ANGLE_W-mcfe_pkg::DIV_DIGIT_W-1:0],
                 {mcfe_pkg::DIV_DIGIT_W{1'b0}}};
      rem_r  <= diff[3:0];
      quot_r <= {quot_r[mcfe_pkg::QUOT_W-mcfe_pkg::DIV_DIGIT_W-1:0], qd};
    end
  end

  // restore the sign on the low quotient word
  assign done     = done_r;
  assign quotient = neg_r ? (~quot_r + {{(mcfe_pkg::QUOT_W-1){1'b0}}, 1'b1}) : quot_r;

endmodule

FILE: rtl/motor_command_frame_encoder.sv
// ----------------------------------------------------------------------------
// motor_command_frame_encoder
// Turns one motor command word into its serial frame, one byte per word on
// the output channel.
// ----------------------------------------------------------------------------
// A command is taken only while in_ready is high; the block then sends the
// frame one byte per cycle while out_ready is high, through a single output
// register: 5 bytes for connect, servo off/on and read position, 14 for
// move, 18 for move with speed and 10 for set position, with out_last_byte
// on the final byte. in_ready returns in the cycle after the final byte is
// loaded. Set position first runs the divide-by-ten unit, one 16-bit digit
// of the 64-bit angle per cycle. Action code 7 is dropped without output.
// Output stalls hold the byte sequencer; nothing is lost.
// ----------------------------------------------------------------------------
module motor_command_frame_encoder (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic        [2:0]                   in_action,
  input  logic        [7:0]                   in_motor_id,
  input  logic signed [mcfe_pkg::ANGLE_W-1:0] in_angle,
  input  logic signed [mcfe_pkg::SPEED_W-1:0] in_speed,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic        [7:0]                   out_frame_byte,
  output logic                                out_last_byte
);

  mcfe_pkg::state_t               state_r, state_nxt;
  logic [mcfe_pkg::HDR_W-1:0]     hdr_r;
  logic [mcfe_pkg::PAY_W-1:0]     pay_r;
  logic [7:0]                     sum_r;
  logic [4:0]                     pos_r;
  logic [4:0]                     last_pos_r;
  logic                           out_valid_r;
  logic [7:0]                     out_byte_r;
  logic                           out_last_r;

  logic                           accept;
  logic                           act_ok;
  logic                           is_move;
  logic                           is_move_spd;
  logic                           is_set_pos;
  logic [4:0]                     len;
  logic                           div_start;
  logic                           div_done;
  logic [mcfe_pkg::QUOT_W-1:0]    div_quot;
  logic                           load;
  logic                           is_sum_pos;
  logic                           at_last;
  logic [7:0]                     emit_byte;

  // command decode
  always_comb begin
    accept      = in_valid && in_ready;
    act_ok      = (in_action <= mcfe_pkg::ACT_SET_POS);
    is_move     = (in_action == mcfe_pkg::ACT_MOVE);
    is_move_spd = (in_action == mcfe_pkg::ACT_MOVE_SPD);
    is_set_pos  = (in_action == mcfe_pkg::ACT_SET_POS);
    len         = mcfe_pkg::cmd_len(in_action);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mcfe_pkg::ST_IDLE: begin
        if (accept && act_ok) begin
          state_nxt = is_set_pos ? mcfe_pkg::ST_DIV : mcfe_pkg::ST_EMIT;
        end
      end
      mcfe_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = mcfe_pkg::ST_EMIT;
        end
      end
      mcfe_pkg::ST_EMIT: begin
        if (load && at_last) begin
          state_nxt = mcfe_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mcfe_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    load      = 1'b0;
    case (state_r)
      mcfe_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        div_start = in_valid && act_ok && is_set_pos;
      end
      mcfe_pkg::ST_DIV: begin
        in_ready = 1'b0;
      end
      mcfe_pkg::ST_EMIT: begin
        load = !out_valid_r || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // byte select: header, header sum, data, data sum
  always_comb begin
    at_last    = (pos_r == last_pos_r);
    is_sum_pos = (pos_r == mcfe_pkg::HDR_SUM_POS) || at_last;
    if (pos_r < mcfe_pkg::HDR_BYTES) begin
      emit_byte = hdr_r[7:0];
    end else if (is_sum_pos) begin
      emit_byte = sum_r;
    end else begin
      emit_byte = pay_r[7:0];
    end
  end

  // divide-by-ten unit for set position
  mcfe_div10 u_div10 (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_angle),
    .done     (div_done),
    .quotient (div_quot)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mcfe_pkg::ST_IDLE;
      pos_r       <= '0;
      last_pos_r  <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept && act_ok) begin
        pos_r      <= '0;
        sum_r      <= '0;
        last_pos_r <= (len == 5'd0) ? mcfe_pkg::HDR_SUM_POS : (len + mcfe_pkg::DATA_START);
      end else if (load) begin
        pos_r <= pos_r + 1'b1;
        sum_r <= (pos_r == mcfe_pkg::HDR_SUM_POS) ? 8'h00 : (sum_r + emit_byte);
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // header and data shift registers, output word
  always_ff @(posedge clk) begin
    if (accept && act_ok) begin
      hdr_r <= {{3'b000, len}, in_motor_id, mcfe_pkg::cmd_code(in_action),
                mcfe_pkg::HDR_MAGIC};
      pay_r <= {(is_move_spd ? in_speed : {mcfe_pkg::SPEED_W{1'b0}}),
                ((is_move || is_move_spd) ? in_angle : {mcfe_pkg::ANGLE_W{1'b0}})};
    end else if (div_done) begin
      pay_r <= {{(mcfe_pkg::PAY_W - mcfe_pkg::QUOT_W){1'b0}}, div_quot};
    end else if (load) begin
      if (pos_r < mcfe_pkg::HDR_BYTES) begin
        hdr_r <= {8'h00, hdr_r[mcfe_pkg::HDR_W-1:8]};
      end else if (!is_sum_pos) begin
        pay_r <= {8'h00, pay_r[mcfe_pkg::PAY_W-1:8]};
      end
    end
    if (load) begin
      out_byte_r <= emit_byte;
      out_last_r <= at_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_frame_byte = out_byte_r;
  assign out_last_byte  = out_last_r;

  // divider finishes only while the sequencer waits for it
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == mcfe_pkg::ST_DIV))
    else $error("divider done outside divide state");

  // byte position never runs past the frame end
  a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mcfe_pkg::ST_EMIT) |-> (pos_r <= last_pos_r))
    else $error("byte position beyond frame end");

  // frame end is one of the legal frame lengths
  a_frame_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != mcfe_pkg::ST_IDLE) |->
      (last_pos_r == 5'd4 || last_pos_r == 5'd9 || last_pos_r == 5'd13 ||
       last_pos_r == 5'd17))
    else $error("illegal frame length");

  // loading the final byte returns the sequencer to idle
  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mcfe_pkg::ST_EMIT && load && at_last) |=> (state_r == mcfe_pkg::ST_IDLE))
    else $error("sequencer did not finish after final byte");

  // no last flag on the header sum byte of a data frame
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (load && (pos_r == mcfe_pkg::HDR_SUM_POS) && (last_pos_r != mcfe_pkg::HDR_SUM_POS))
      |=> !out_last_r)
    else $error("last flag set on header sum of a data frame");

endmodule

FILE: tb/motor_command_frame_encoder_tb.sv
// ----------------------------------------------------------------------------
// motor_command_frame_encoder_tb
// Self-checking testbench for the motor command frame encoder. Commands go in
// through a valid/ready driver. Every accepted command is turned into its
// expected frame bytes, and each byte that comes out is checked against the
// oldest one still waiting. The run has directed corner cases, a long output
// hold-off, a full drain pause, a random mix with idle bursts on both sides
// and a final stream with no idling.
// ----------------------------------------------------------------------------
module motor_command_frame_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // the dropped action
  localparam logic [2:0] ACT_UNUSED     = 3'd7;

  localparam logic [63:0] ANGLE_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ANGLE_MIN = 64'h8000_0000_0000_0000;
  localparam logic [31:0] SPEED_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] SPEED_MIN = 32'h8000_0000;

  localparam int RESET_CYCLES   = 12;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int END_WAIT       = 120;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_word_t;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic        [2:0]                   in_action = '0;
  logic        [7:0]                   in_motor_id = '0;
  logic signed [mcfe_pkg::ANGLE_W-1:0] in_angle = '0;
  logic signed [mcfe_pkg::SPEED_W-1:0] in_speed = '0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic        [7:0]                   out_frame_byte;
  logic                                out_last_byte;

  frame_word_t expected_words[$];
  int          errors = 0;
  int          words_checked = 0;
  int          frames_by_action[8];
  int          stalled_cycles = 0;
  bit          idle_en = 1'b1;
  int          hold_requests = 0;
  int          holds_served = 0;
  int          stall_left = 0;

  motor_command_frame_encoder i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_motor_id   (in_motor_id),
    .in_angle      (in_angle),
    .in_speed      (in_speed),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_frame_byte(out_frame_byte),
    .out_last_byte (out_last_byte)
  );

  // clock
  always #6 clk = ~clk;

  // angle / 10 truncated toward zero, low 32 bits kept
  function automatic logic [31:0] angle_div10(input logic [63:0] ang);
    logic [63:0] mag;
    logic [63:0] quot;
    mag  = ang[63] ? (64'd0 - ang) : ang;
    quot = mag / 64'd10;
    if (ang[63]) quot = 64'd0 - quot;
    return quot[31:0];
  endfunction

  // append one expected word at the tail of the queue
  function automatic void add_expected(input logic [7:0] data, input logic last);
    frame_word_t w;
    w.data = data;
    w.last = last;
    expected_words.insert(expected_words.size(), w);
  endfunction

  // queue the frame bytes one command produces
  function automatic void predict_frame(input logic [2:0] act, input logic [7:0] id,
                                        input logic [63:0] ang, input logic [31:0] spd);
    logic [7:0]  code;
    logic [4:0]  len;
    logic [95:0] payload;
    logic [7:0]  hdr_sum;
    logic [7:0]  data_sum;
    frames_by_action[act]++;
    if (act == ACT_UNUSED) return;
    payload = '0;
    case (act)
      mcfe_pkg::ACT_CONNECT: begin
        code = mcfe_pkg::CODE_CONNECT;
        len  = 5'd0;
      end
      mcfe_pkg::ACT_SERVO_OFF: begin
        code = mcfe_pkg::CODE_SERVO_OFF;
        len  = 5'd0;
      end
      mcfe_pkg::ACT_SERVO_ON: begin
        code = mcfe_pkg::CODE_SERVO_ON;
        len  = 5'd0;
      end
      mcfe_pkg::ACT_READ_POS: begin
        code = mcfe_pkg::CODE_READ_POS;
        len  = 5'd0;
      end
      mcfe_pkg::ACT_MOVE: begin
        code = mcfe_pkg::CODE_MOVE;
        len  = 5'd8;
        payload[63:0] = ang;
      end
      mcfe_pkg::ACT_MOVE_SPD: begin
        code = mcfe_pkg::CODE_MOVE_SPD;
        len  = 5'd12;
        payload = {spd, ang};
      end
      default: begin
        code = mcfe_pkg::CODE_SET_POS;
        len  = 5'd4;
        payload[31:0] = angle_div10(ang);
      end
    endcase
    hdr_sum = mcfe_pkg::HDR_MAGIC + code + id + {3'b000, len};
    add_expected(mcfe_pkg::HDR_MAGIC, 1'b0);
    add_expected(code, 1'b0);
    add_expected(id, 1'b0);
    add_expected({3'b000, len}, 1'b0);
    add_expected(hdr_sum, len == 5'd0);
    if (len != 5'd0) begin
      data_sum = 8'h00;
      for (int i = 0; i < len; i++) begin
        add_expected(payload[8*i +: 8], 1'b0);
        data_sum += payload[8*i +: 8];
      end
      add_expected(data_sum, 1'b1);
    end
  endfunction

  function automatic void note_mismatch(input string msg);
    if (errors < MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endfunction

  // compare one output word with the oldest expectation
  function automatic void check_frame_word(input logic [7:0] data, input logic last);
    frame_word_t want;
    if (expected_words.size() == 0) begin
      note_mismatch($sformatf("unexpected word byte=%02h last=%0b", data, last));
      return;
    end
    want = expected_words.pop_front();
    words_checked++;
    if (data !== want.data)
      note_mismatch($sformatf("frame_byte expected %02h got %02h", want.data, data));
    if (last !== want.last)
      note_mismatch($sformatf("last_byte expected %0b got %0b (byte %02h)",
                              want.last, last, want.data));
  endfunction

  // monitor: predict on input handshake, check on output handshake
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        predict_frame(in_action, in_motor_id, in_angle, in_speed);
      if (out_valid && out_ready)
        check_frame_word(out_frame_byte, out_last_byte);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stalled_cycles = 0;
      else stalled_cycles++;
    end
  end

  // receiver: random stall bursts plus the long hold-off on request
  always @(negedge clk) begin
    if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      stall_left   = LONG_HOLD;
    end else if (stall_left == 0 && idle_en && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 17);
    end
    if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog on cycles with no handshake at all
  initial begin
    while (stalled_cycles < WATCHDOG_LIMIT) @(negedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  // offer one command and wait until it is taken
  task automatic send_command(input logic [2:0] act, input logic [7:0] id,
                              input logic [63:0] ang, input logic [31:0] spd);
    int gap;
    gap = 0;
    if (idle_en && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 17);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_action   <= act;
    in_motor_id <= id;
    in_angle    <= ang;
    in_speed    <= spd;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic stop_offering();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_words.size() != 0) @(negedge clk);
  endtask

  function automatic logic [63:0] random_angle();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 6))
      0:       return ANGLE_MAX;
      1:       return ANGLE_MIN;
      2:       return {{32{r[31]}}, r};
      3:       return 64'($signed($urandom_range(0, 2000000))) - 64'sd1000000;
      4:       return 64'($signed($urandom_range(0, 40))) - 64'sd20;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [31:0] random_speed();
    case ($urandom_range(0, 5))
      0:       return SPEED_MAX;
      1:       return SPEED_MIN;
      2:       return $urandom_range(0, 360000);
      default: return $urandom;
    endcase
  endfunction

  // pick an action, mostly real commands with the odd dropped one
  function automatic logic [2:0] random_action();
    if ($urandom_range(0, 11) == 0) return ACT_UNUSED;
    return 3'($urandom_range(0, 6));
  endfunction

  // every command at the field extremes, divide corner cases, dropped action
  task automatic test_directed_frames();
    send_command(mcfe_pkg::ACT_CONNECT,   8'h00, ANGLE_MAX, SPEED_MAX);
    send_command(mcfe_pkg::ACT_SERVO_OFF, 8'hFF, ANGLE_MIN, SPEED_MIN);
    send_command(mcfe_pkg::ACT_SERVO_ON,  8'hA5, 64'd0, 32'd0);
    send_command(mcfe_pkg::ACT_READ_POS,  8'h5A, {64{1'b1}}, {32{1'b1}});
    send_command(mcfe_pkg::ACT_MOVE,      8'h01, 64'd0, 32'd0);
    send_command(mcfe_pkg::ACT_MOVE,      8'hFF, ANGLE_MAX, 32'd0);
    send_command(mcfe_pkg::ACT_MOVE,      8'h80, ANGLE_MIN, 32'd0);
    send_command(mcfe_pkg::ACT_MOVE,      8'h7F, {64{1'b1}}, 32'd0);
    send_command(mcfe_pkg::ACT_MOVE_SPD,  8'h00, 64'd0, SPEED_MAX);
    send_command(mcfe_pkg::ACT_MOVE_SPD,  8'hFF, ANGLE_MIN, SPEED_MIN);
    send_command(mcfe_pkg::ACT_MOVE_SPD,  8'hC3, {64{1'b1}}, {32{1'b1}});
    send_command(mcfe_pkg::ACT_SET_POS,   8'h10, 64'd0, 32'd0);
    send_command(mcfe_pkg::ACT_SET_POS,   8'h11, ANGLE_MAX, 32'd0);
    send_command(mcfe_pkg::ACT_SET_POS,   8'h12, ANGLE_MIN, 32'd0);
    send_command(mcfe_pkg::ACT_SET_POS,   8'h13, -64'sd9, 32'd0);
    send_command(mcfe_pkg::ACT_SET_POS,   8'h14, -64'sd19, 32'd0);
    send_command(mcfe_pkg::ACT_SET_POS,   8'h15, 64'sd9, 32'd0);
    send_command(ACT_UNUSED,              8'h22, ANGLE_MAX, SPEED_MAX);
    send_command(mcfe_pkg::ACT_SET_POS,   8'h16, 64'sd123456789, 32'd0);
    send_command(mcfe_pkg::ACT_SET_POS,   8'h17, -64'sd1000, 32'd0);
    send_command(ACT_UNUSED,              8'h33, ANGLE_MIN, SPEED_MIN);
    send_command(mcfe_pkg::ACT_CONNECT,   8'hFF, 64'd0, 32'd0);
  endtask

  // receiver holds off long while commands keep coming
  task automatic test_output_backpressure();
    hold_requests++;
    repeat (8)
      send_command(3'($urandom_range(4, 6)), 8'($urandom), random_angle(), random_speed());
  endtask

  // sender waits until every frame is out, then resumes
  task automatic test_drain_pause();
    repeat (5) send_command(random_action(), 8'($urandom), random_angle(), random_speed());
    stop_offering();
    wait_drained();
    repeat (5) send_command(random_action(), 8'($urandom), random_angle(), random_speed());
  endtask

  // random mix with idle bursts on both sides
  task automatic test_random_commands(input int count);
    logic [2:0] act;
    int         sent;
    sent = 0;
    while (sent < count) begin
      act = random_action();
      send_command(act, 8'($urandom), random_angle(), random_speed());
      if (act != ACT_UNUSED) sent++;
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    test_directed_frames();
    test_output_backpressure();
    test_drain_pause();
    test_random_commands(170);
    // last stretch runs with neither side idling
    idle_en = 1'b0;
    test_random_commands(40);

    stop_offering();
    wait_drained();
    repeat (END_WAIT) @(negedge clk);
    if (expected_words.size() != 0)
      note_mismatch($sformatf("%0d expected words never came", expected_words.size()));

    $display("commands: connect %0d, servo off %0d, servo on %0d, read pos %0d, move %0d,",
             frames_by_action[0], frames_by_action[1], frames_by_action[2],
             frames_by_action[3], frames_by_action[4]);
    $display("  move+speed %0d, set pos %0d, dropped %0d; %0d words checked",
             frames_by_action[5], frames_by_action[6], frames_by_action[7], words_checked);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/mcfe_pkg.sv
rtl/mcfe_div10.sv
rtl/motor_command_frame_encoder.sv
tb/motor_command_frame_encoder_tb.sv
